/* src/wredq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wredq_pkg;

	// Field widths of the two channels.
	localparam int SIZE_W    = 16;
	localparam int FLOW_W    = 8;
	localparam int RND_W     = 31;
	localparam int TIME_W    = 32;
	localparam int VERDICT_W = 3;
	localparam int PKTS_W    = 16;
	localparam int BYTES_W   = 25;

	// Register widths.
	localparam int CNT_LIM_W = 16;
	localparam int BYTE_LIM_W = 24;
	localparam int RAMP_W    = 16;
	localparam int DENOM_W   = 8;
	localparam int RATE_W    = 16;
	localparam int LAT_W     = 20;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_COUNT_LIMIT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BYTE_LIMIT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_MIN      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_MAX      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_DENOM    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_FLOW     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LINE_RATE     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_EXTRA_LATENCY = 3'd7;

	localparam logic [RAMP_W-1:0]  RAMP_MIN_RESET   = 16'd5;
	localparam logic [RAMP_W-1:0]  RAMP_MAX_RESET   = 16'd20;
	localparam logic [DENOM_W-1:0] RAMP_DENOM_RESET = 8'd8;
	localparam logic [FLOW_W-1:0]  RAMP_FLOW_RESET  = 8'd1;
	localparam logic [RATE_W-1:0]  LINE_RATE_RESET  = 16'd1000;

	// Verdict codes.
	localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT     = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_COUNT_DROP = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_BYTE_DROP  = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_RAND_DROP  = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_DEQUEUED   = 3'd4;

	localparam logic KIND_ENQUEUE = 1'b0;
	localparam logic KIND_DEQUEUE = 1'b1;

	// Shared divider: dividend, divisor and step count.
	localparam int DIV_N_W   = 32;
	localparam int DIV_D_W   = 24;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);
	// Serialization interval: pkt_size * 8 fits in this many bits.
	localparam int INTV_W    = SIZE_W + 3;

	typedef struct packed {
		logic [CNT_LIM_W-1:0]  count_limit;
		logic [BYTE_LIM_W-1:0] byte_limit;
		logic [RAMP_W-1:0]     ramp_min;
		logic [RAMP_W-1:0]     ramp_max;
		logic [DENOM_W-1:0]    ramp_denominator;
		logic [FLOW_W-1:0]     ramp_flow;
		logic [RATE_W-1:0]     line_rate;
		logic [LAT_W-1:0]      extra_latency;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

/* src/wredq_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wredq_in_if;
	import wredq_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [SIZE_W-1:0] pkt_size;
	logic [FLOW_W-1:0] flow_id;
	logic [RND_W-1:0]  random_value;
	logic [TIME_W-1:0] now_us;

	modport source (
		output valid, kind, pkt_size, flow_id, random_value, now_us,
		input  ready
	);

	modport sink (
		input  valid, kind, pkt_size, flow_id, random_value, now_us,
		output ready
	);
endinterface

`default_nettype wire

/* src/wredq_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wredq_out_if;
	import wredq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic [PKTS_W-1:0]    queue_packets;
	logic [BYTES_W-1:0]   queue_bytes;
	logic [TIME_W-1:0]    depart_time_us;

	modport source (
		output valid, verdict, queue_packets, queue_bytes, depart_time_us,
		input  ready
	);

	modport sink (
		input  valid, verdict, queue_packets, queue_bytes, depart_time_us,
		output ready
	);
endinterface

`default_nettype wire

/* src/wredq_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module wredq_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [wredq_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [wredq_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [wredq_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready,
	output wredq_pkg::cfg_t                       cfg
);
	import wredq_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_limit      <= '0;
			cfg_q.byte_limit       <= '0;
			cfg_q.ramp_min         <= RAMP_MIN_RESET;
			cfg_q.ramp_max         <= RAMP_MAX_RESET;
			cfg_q.ramp_denominator <= RAMP_DENOM_RESET;
			cfg_q.ramp_flow        <= RAMP_FLOW_RESET;
			cfg_q.line_rate        <= LINE_RATE_RESET;
			cfg_q.extra_latency    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_COUNT_LIMIT:   cfg_q.count_limit      <= pwdata[CNT_LIM_W-1:0];
				REG_BYTE_LIMIT:    cfg_q.byte_limit       <= pwdata[BYTE_LIM_W-1:0];
				REG_RAMP_MIN:      cfg_q.ramp_min         <= pwdata[RAMP_W-1:0];
				REG_RAMP_MAX:      cfg_q.ramp_max         <= pwdata[RAMP_W-1:0];
				REG_RAMP_DENOM:    cfg_q.ramp_denominator <= pwdata[DENOM_W-1:0];
				REG_RAMP_FLOW:     cfg_q.ramp_flow        <= pwdata[FLOW_W-1:0];
				REG_LINE_RATE:     cfg_q.line_rate        <= pwdata[RATE_W-1:0];
				REG_EXTRA_LATENCY: cfg_q.extra_latency    <= pwdata[LAT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COUNT_LIMIT:   prdata = APB_DATA_W'(cfg_q.count_limit);
			REG_BYTE_LIMIT:    prdata = APB_DATA_W'(cfg_q.byte_limit);
			REG_RAMP_MIN:      prdata = APB_DATA_W'(cfg_q.ramp_min);
			REG_RAMP_MAX:      prdata = APB_DATA_W'(cfg_q.ramp_max);
			REG_RAMP_DENOM:    prdata = APB_DATA_W'(cfg_q.ramp_denominator);
			REG_RAMP_FLOW:     prdata = APB_DATA_W'(cfg_q.ramp_flow);
			REG_LINE_RATE:     prdata = APB_DATA_W'(cfg_q.line_rate);
			REG_EXTRA_LATENCY: prdata = APB_DATA_W'(cfg_q.extra_latency);
		endcase
	end
endmodule

`default_nettype wire

/* src/wredq_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module wredq_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wredq_pkg::DIV_N_W-1:0] dividend,
	input  wire logic [wredq_pkg::DIV_D_W-1:0] divisor,
	output logic      [wredq_pkg::DIV_N_W-1:0] quotient,
	output logic      [wredq_pkg::DIV_D_W-1:0] remainder,
	output wredq_pkg::div_sts_t                sts
);
	import wredq_pkg::*;

	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_D_W:0]     trial;
	logic [DIV_D_W:0]     diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// The partial remainder stays below the divisor, so its top bit drops.
			rem_q <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign sts.busy  = cnt_q != '0;
	assign sts.done  = done_q;
endmodule

`default_nettype wire

/* src/wred_queue_admission.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake      Content
// req       sink       valid/ready    kind, pkt_size, flow_id, random_value, now_us
// rsp       source     valid/ready    verdict, queue_packets, queue_bytes, depart_time_us
// APB       slave      psel/penable   eight configuration registers at 4*index
//
// Every item passes, from its transfer to its result being registered, through
// one preparation step, the divider load, the 32 steps of the shared restoring
// divider, its done flag and the final step. The divider gives the random
// remainder for an enqueue and the serialization interval for a dequeue.
// The input is ready only while the sequencer is idle, so a new request is not
// taken before the block is through with the last one.
// Reset (arst_n low) clears the queue state, the sequencer and the result valid.
// A new item is taken while a finished result still waits on rsp; the block then
// holds in its final step until the result register frees up.

module wred_queue_admission (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [wredq_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [wredq_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [wredq_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready,
	wredq_in_if.sink                              req,
	wredq_out_if.source                           rsp
);
	import wredq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PREP   = 5'b00010,
		S_START  = 5'b00100,
		S_WAIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	localparam logic [PKTS_W-1:0]  PKT_MAX  = '1;
	localparam logic [BYTES_W-1:0] BYTE_MAX = '1;

	cfg_t      cfg;
	div_sts_t  div_sts;
	state_t    state_q;

	// Accepted item.
	logic              kind_q;
	logic [SIZE_W-1:0] size_q;
	logic [FLOW_W-1:0] flow_q;
	logic [RND_W-1:0]  rnd_q;
	logic [TIME_W-1:0] now_q;

	// Queue state.
	logic [PKTS_W-1:0]  pkts_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [TIME_W-1:0]  last_q;

	// Values prepared before the division.
	logic [DIV_D_W-1:0] ramp_n_q;
	logic [TIME_W-1:0]  start_q;

	// Result register.
	logic                 rsp_valid_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic [PKTS_W-1:0]    rsp_pkts_q;
	logic [BYTES_W-1:0]   rsp_bytes_q;
	logic [TIME_W-1:0]    rsp_depart_q;

	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic [DIV_N_W-1:0] div_quo;
	logic [DIV_D_W-1:0] div_rem;
	logic [RATE_W-1:0]  rate_nz;

	logic               take_item;
	logic               finish_go;
	logic               ramp_drop;
	logic [RAMP_W-1:0]  ramp_m;
	logic [DIV_D_W:0]   rem_plus1;
	logic [BYTES_W:0]   bytes_sum;
	logic [TIME_W-1:0]  last_new;

	logic [VERDICT_W-1:0] verdict_d;
	logic [PKTS_W-1:0]    pkts_d;
	logic [BYTES_W-1:0]   bytes_d;
	logic [TIME_W-1:0]    depart_d;

	wredq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A zero line rate counts as one bit per microsecond.
	assign rate_nz = (cfg.line_rate == '0) ? RATE_W'(1) : cfg.line_rate;

	// An enqueue divides the random value by the ramp span; a dequeue divides
	// the packet's bit count by the line rate.
	assign div_dividend = (kind_q == KIND_DEQUEUE) ?
		DIV_N_W'({size_q, 3'b000}) : DIV_N_W'(rnd_q);
	assign div_divisor = (kind_q == KIND_DEQUEUE) ? DIV_D_W'(rate_nz) : ramp_n_q;

	wredq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_START),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.sts       (div_sts)
	);

	assign req.ready = (state_q == S_IDLE);
	assign take_item = req.valid && req.ready;
	assign finish_go = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);

	// Random early drop ramp. When the span is zero the count is past it, so
	// the remainder of that division is never looked at.
	always_comb begin
		ramp_m    = pkts_q - cfg.ramp_min;
		rem_plus1 = {1'b0, div_rem} + 1'b1;
		priority if (cfg.ramp_max < cfg.ramp_min) begin
			ramp_drop = 1'b0;
		end else if (cfg.ramp_max == cfg.ramp_min) begin
			ramp_drop = 1'b1;
		end else if (pkts_q > cfg.ramp_max) begin
			ramp_drop = 1'b1;
		end else if (pkts_q <= cfg.ramp_min) begin
			ramp_drop = 1'b0;
		end else if (DIV_D_W'(ramp_m) > ramp_n_q) begin
			ramp_drop = 1'b1;
		end else begin
			ramp_drop = rem_plus1 <= (DIV_D_W + 1)'(ramp_m);
		end
	end

	// Verdict and next queue state.
	always_comb begin
		bytes_sum = {1'b0, bytes_q} + (BYTES_W + 1)'(size_q);
		last_new  = start_q + TIME_W'(div_quo[INTV_W-1:0]);
		verdict_d = VERDICT_ACCEPT;
		pkts_d    = pkts_q;
		bytes_d   = bytes_q;
		depart_d  = '0;
		if (kind_q == KIND_DEQUEUE) begin
			verdict_d = VERDICT_DEQUEUED;
			pkts_d    = (pkts_q != '0) ? pkts_q - 1'b1 : '0;
			bytes_d   = (bytes_q > BYTES_W'(size_q)) ? bytes_q - BYTES_W'(size_q) : '0;
			depart_d  = last_new + TIME_W'(cfg.extra_latency);
		end else begin
			priority if (cfg.count_limit != '0 && pkts_q >= cfg.count_limit) begin
				verdict_d = VERDICT_COUNT_DROP;
			end else if (cfg.byte_limit != '0 && bytes_q >= BYTES_W'(cfg.byte_limit)) begin
				verdict_d = VERDICT_BYTE_DROP;
			end else if (flow_q == cfg.ramp_flow && ramp_drop) begin
				verdict_d = VERDICT_RAND_DROP;
			end else begin
				verdict_d = VERDICT_ACCEPT;
				pkts_d    = (pkts_q < PKT_MAX) ? pkts_q + 1'b1 : PKT_MAX;
				bytes_d   = bytes_sum[BYTES_W] ? BYTE_MAX : bytes_sum[BYTES_W-1:0];
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take_item) begin
						state_q <= S_PREP;
					end
				end
				S_PREP:  state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_sts.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Queue state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkts_q      <= '0;
			bytes_q     <= '0;
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (finish_go) begin
				pkts_q      <= pkts_d;
				bytes_q     <= bytes_d;
				rsp_valid_q <= 1'b1;
				if (kind_q == KIND_DEQUEUE) begin
					last_q <= last_new;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, preparation and result payload.
	always_ff @(posedge clk) begin
		if (take_item) begin
			kind_q <= req.kind;
			size_q <= req.pkt_size;
			flow_q <= req.flow_id;
			rnd_q  <= req.random_value;
			now_q  <= req.now_us;
		end
		if (state_q == S_PREP) begin
			// The span only matters when ramp_max exceeds ramp_min. The product
			// of the 8-bit denominator and the 16-bit span needs all 24 bits.
			ramp_n_q <= DIV_D_W'(cfg.ramp_denominator) *
				DIV_D_W'(cfg.ramp_max - cfg.ramp_min);
			start_q  <= (last_q > now_q) ? last_q : now_q;
		end
		if (finish_go) begin
			verdict_q    <= verdict_d;
			rsp_pkts_q   <= pkts_d;
			rsp_bytes_q  <= bytes_d;
			rsp_depart_q <= depart_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.verdict        = verdict_q;
	assign rsp.queue_packets  = rsp_pkts_q;
	assign rsp.queue_bytes    = rsp_bytes_q;
	assign rsp.depart_time_us = rsp_depart_q;
endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the WRED queue admission block.
//
// Every packet event offered on the request channel is run through a local
// model of the queue (packet count, byte occupancy, last departure time and a
// shadow copy of the eight registers) at the moment of its transfer. The model
// output is queued, and each result transfer on the response channel is
// compared field by field with the oldest queued entry.
//
// The run has three parts. A short directed table comes first: dequeues on an
// empty queue, time wrap, the ramp edges (min equal to max, max below min, a
// zero denominator), count and byte drops, a zero line rate and the largest
// latency. A few rows carry a hand-written result. Then come several phases
// of random register settings with random packet events, one of which starts
// with a long output stall so that the block backs up into its input. Last,
// a flood of maximum-size enqueues drives the byte occupancy into saturation,
// with no idling on either side.

module tb_top;
	import wredq_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_EVENTS  = 63;
	localparam int FLOOD_EVENTS  = 520;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 60;

	localparam logic [PKTS_W-1:0]  PKT_CEIL  = '1;
	localparam logic [BYTES_W-1:0] BYTE_CEIL = '1;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] size;
		logic [FLOW_W-1:0] flow;
		logic [RND_W-1:0]  rnd;
		logic [TIME_W-1:0] now;
	} pkt_event_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [PKTS_W-1:0]    pkts;
		logic [BYTES_W-1:0]   bytes;
		logic [TIME_W-1:0]    depart;
	} queue_report_t;

	// One row of the directed table: either a register write or a packet
	// event, the latter optionally with its result written out by hand.
	typedef struct packed {
		row_kind_t              what;
		logic [REG_IDX_W-1:0]   reg_idx;
		logic [APB_DATA_W-1:0]  value;
		pkt_event_t             ev;
		logic                   has_want;
		queue_report_t          want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	wredq_in_if  req_ch ();
	wredq_out_if rsp_ch ();

	wred_queue_admission DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// Shadow of the block: its registers and its queue state.
	cfg_t                shadow_cfg;
	logic [PKTS_W-1:0]   model_pkts;
	logic [BYTES_W-1:0]  model_bytes;
	logic [TIME_W-1:0]   model_last;
	logic [TIME_W-1:0]   wall_clock;

	// Results predicted for accepted events, oldest first.
	queue_report_t pending_reports[$];

	int   mismatches    = 0;
	int   cycles        = 0;
	int   events_sent   = 0;
	int   settings_made = 0;
	logic calm          = 1'b0;
	logic hold_pending  = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog. A correct run ends far below this count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Random early drop ramp, evaluated on the count before the enqueue.
	// A zero denominator makes the span zero, so every count inside the
	// ramp drops without the modulo being reached.
	function automatic logic early_drop(logic [PKTS_W-1:0] depth, logic [RND_W-1:0] rnd);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] den;
		logic [31:0] over;
		logic [31:0] span;
		lo  = 32'(shadow_cfg.ramp_min);
		hi  = 32'(shadow_cfg.ramp_max);
		den = 32'(shadow_cfg.ramp_denominator);
		if (hi < lo)
			return 1'b0;
		if (hi == lo)
			return 1'b1;
		if (32'(depth) > hi)
			return 1'b1;
		if (32'(depth) <= lo)
			return 1'b0;
		over = 32'(depth) - lo;
		span = den * (hi - lo);
		if (over > span)
			return 1'b1;
		return ((32'(rnd) % span) + 32'd1) <= over;
	endfunction

	// Applies one packet event to the shadow queue and returns the result the
	// block must give for it. All time sums wrap at 32 bits.
	function automatic queue_report_t admit_or_depart(pkt_event_t ev);
		queue_report_t rep;
		logic [31:0]   rate;
		logic [31:0]   gap;
		logic [31:0]   start;
		logic [31:0]   sum;
		rep = '0;
		if (ev.kind == KIND_ENQUEUE) begin
			if (shadow_cfg.count_limit != '0 && model_pkts >= shadow_cfg.count_limit) begin
				rep.verdict = VERDICT_COUNT_DROP;
			end else if (shadow_cfg.byte_limit != '0
					&& model_bytes >= BYTES_W'(shadow_cfg.byte_limit)) begin
				rep.verdict = VERDICT_BYTE_DROP;
			end else if (ev.flow == shadow_cfg.ramp_flow && early_drop(model_pkts, ev.rnd)) begin
				rep.verdict = VERDICT_RAND_DROP;
			end else begin
				// Admitted: both counters saturate at their ceilings.
				rep.verdict = VERDICT_ACCEPT;
				if (model_pkts != PKT_CEIL)
					model_pkts = model_pkts + 1'b1;
				sum = 32'(model_bytes) + 32'(ev.size);
				model_bytes = (sum > 32'(BYTE_CEIL)) ? BYTE_CEIL : sum[BYTES_W-1:0];
			end
		end else begin
			// A zero line rate is taken as one bit per microsecond.
			rate  = (shadow_cfg.line_rate == '0) ? 32'd1 : 32'(shadow_cfg.line_rate);
			gap   = (32'(ev.size) * 32'd8) / rate;
			start = (model_last > ev.now) ? model_last : ev.now;
			rep.verdict = VERDICT_DEQUEUED;
			if (model_pkts != '0)
				model_pkts = model_pkts - 1'b1;
			model_bytes = (model_bytes > BYTES_W'(ev.size)) ? model_bytes - BYTES_W'(ev.size) : '0;
			model_last  = start + gap;
			rep.depart  = model_last + 32'(shadow_cfg.extra_latency);
		end
		rep.pkts  = model_pkts;
		rep.bytes = model_bytes;
		return rep;
	endfunction

	function automatic stim_row_t ev_row(logic k, logic [SIZE_W-1:0] sz, logic [FLOW_W-1:0] fl,
			logic [RND_W-1:0] rn, logic [TIME_W-1:0] tm);
		stim_row_t r;
		r = '0;
		r.what    = ROW_ITEM;
		r.ev.kind = k;
		r.ev.size = sz;
		r.ev.flow = fl;
		r.ev.rnd  = rn;
		r.ev.now  = tm;
		return r;
	endfunction

	function automatic stim_row_t want_row(logic k, logic [SIZE_W-1:0] sz, logic [FLOW_W-1:0] fl,
			logic [RND_W-1:0] rn, logic [TIME_W-1:0] tm, logic [VERDICT_W-1:0] v,
			logic [PKTS_W-1:0] p, logic [BYTES_W-1:0] b, logic [TIME_W-1:0] d);
		stim_row_t r;
		r = ev_row(k, sz, fl, rn, tm);
		r.has_want       = 1'b1;
		r.want.verdict   = v;
		r.want.pkts      = p;
		r.want.bytes     = b;
		r.want.depart    = d;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.what    = ROW_WRITE;
		r.reg_idx = idx;
		r.value   = val;
		return r;
	endfunction

	// Picks a register value: often one of the two extremes, mostly a value
	// in the range where the block does something interesting.
	function automatic logic [31:0] span_pick(int unsigned lo, int unsigned hi, int unsigned near_hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return $urandom_range(lo, hi);
			default: return $urandom_range(lo, near_hi);
		endcase
	endfunction

	// A random packet event. The enqueue share leans on the queue depth so
	// that the count keeps wandering through the ramp region.
	function automatic pkt_event_t random_event();
		pkt_event_t ev;
		int         lean;
		lean    = (model_pkts > 16'd48) ? 30 : 60;
		ev.kind = ($urandom_range(0, 99) < lean) ? KIND_ENQUEUE : KIND_DEQUEUE;
		case ($urandom_range(0, 15))
			0: ev.size = '0;
			1: ev.size = '1;
			2, 3, 4, 5: ev.size = SIZE_W'($urandom);
			default: ev.size = SIZE_W'($urandom_range(40, 1500));
		endcase
		ev.flow = ($urandom_range(0, 9) < 6) ? shadow_cfg.ramp_flow : FLOW_W'($urandom_range(0, 255));
		// Small draws land the modulo test near its threshold.
		ev.rnd = ($urandom_range(0, 1) == 1) ? RND_W'($urandom) : RND_W'($urandom_range(0, 600));
		if ($urandom_range(0, 19) == 0)
			wall_clock = $urandom;
		else
			wall_clock = wall_clock + $urandom_range(0, 3000);
		ev.now = wall_clock;
		return ev;
	endfunction

	// APB write: setup cycle, then access cycle until pready. The shadow copy
	// takes the value masked to the register width.
	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_COUNT_LIMIT:   shadow_cfg.count_limit      = value[CNT_LIM_W-1:0];
			REG_BYTE_LIMIT:    shadow_cfg.byte_limit       = value[BYTE_LIM_W-1:0];
			REG_RAMP_MIN:      shadow_cfg.ramp_min         = value[RAMP_W-1:0];
			REG_RAMP_MAX:      shadow_cfg.ramp_max         = value[RAMP_W-1:0];
			REG_RAMP_DENOM:    shadow_cfg.ramp_denominator = value[DENOM_W-1:0];
			REG_RAMP_FLOW:     shadow_cfg.ramp_flow        = value[FLOW_W-1:0];
			REG_LINE_RATE:     shadow_cfg.line_rate        = value[RATE_W-1:0];
			REG_EXTRA_LATENCY: shadow_cfg.extra_latency    = value[LAT_W-1:0];
			default: ;
		endcase
		settings_made++;
		// Keeps psel low before returning so a following write starts cleanly.
		@(posedge clk);
	endtask

	// Offers one event, with a random idle burst ahead of it, and records the
	// expected result once the transfer has happened.
	task automatic offer(input pkt_event_t ev, input logic has_want, input queue_report_t want);
		queue_report_t predicted;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= ev.kind;
		req_ch.pkt_size     <= ev.size;
		req_ch.flow_id      <= ev.flow;
		req_ch.random_value <= ev.rnd;
		req_ch.now_us       <= ev.now;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		predicted = admit_or_depart(ev);
		pending_reports.push_back(has_want ? want : predicted);
		events_sent++;
	endtask

	// Stops offering and waits until every expected result has been seen.
	// Every event yields a result, so an empty queue means the block is idle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// A fresh random setting of all eight registers. Now and then the ramp
	// maximum falls at or below the minimum.
	task automatic pick_setting();
		logic [31:0] lo;
		logic [31:0] hi;
		lo = span_pick(0, 65535, 20);
		case ($urandom_range(0, 7))
			0: hi = $urandom_range(0, lo);
			1: hi = 32'd65535;
			default: hi = ((lo + 30) > 65535) ? 32'd65535 : lo + $urandom_range(1, 30);
		endcase
		cfg_write(REG_COUNT_LIMIT, span_pick(0, 65535, 40));
		cfg_write(REG_BYTE_LIMIT, span_pick(0, 16777215, 120000));
		cfg_write(REG_RAMP_MIN, lo);
		cfg_write(REG_RAMP_MAX, hi);
		cfg_write(REG_RAMP_DENOM, span_pick(0, 255, 16));
		cfg_write(REG_RAMP_FLOW, span_pick(0, 255, 255));
		cfg_write(REG_LINE_RATE, span_pick(1, 65535, 20000));
		cfg_write(REG_EXTRA_LATENCY, span_pick(0, 1048575, 5000));
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Result checker: every response transfer is matched with the oldest
	// prediction.
	always @(posedge clk) begin : report_checker
		queue_report_t got;
		queue_report_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.verdict = rsp_ch.verdict;
			got.pkts    = rsp_ch.queue_packets;
			got.bytes   = rsp_ch.queue_bytes;
			got.depart  = rsp_ch.depart_time_us;
			if (pending_reports.size() == 0) begin
				$error("result with verdict %0d arrived with nothing pending", got.verdict);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("verdict", 32'(want.verdict), 32'(got.verdict));
				check_field("queue_packets", 32'(want.pkts), 32'(got.pkts));
				check_field("queue_bytes", 32'(want.bytes), 32'(got.bytes));
				check_field("depart_time_us", want.depart, got.depart);
			end
		end
	end

	// Response pacing: stretches of ready high and short random stalls, plus
	// one long stall on request. In the calm part ready simply stays high.
	initial begin : ready_pacer
		int stretch;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				stretch = LONG_HOLD;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				stretch = $urandom_range(1, 9);
			end else begin
				rsp_ch.ready <= 1'b1;
				stretch = calm ? 1 : $urandom_range(1, 30);
			end
			repeat (stretch - 1) @(posedge clk);
		end
	end

	initial begin : stimulus
		stim_row_t  rows[$];
		pkt_event_t ev;

		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.kind         <= KIND_ENQUEUE;
		req_ch.pkt_size     <= '0;
		req_ch.flow_id      <= '0;
		req_ch.random_value <= '0;
		req_ch.now_us       <= '0;

		shadow_cfg.count_limit      = '0;
		shadow_cfg.byte_limit       = '0;
		shadow_cfg.ramp_min         = RAMP_MIN_RESET;
		shadow_cfg.ramp_max         = RAMP_MAX_RESET;
		shadow_cfg.ramp_denominator = RAMP_DENOM_RESET;
		shadow_cfg.ramp_flow        = RAMP_FLOW_RESET;
		shadow_cfg.line_rate        = LINE_RATE_RESET;
		shadow_cfg.extra_latency    = '0;
		model_pkts  = '0;
		model_bytes = '0;
		model_last  = '0;
		wall_clock  = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, starting from the reset register values
		// (ramp 5..20, denominator 8, flow 1, 1000 bits per microsecond).
		// Dequeues on an empty queue: counts stay at zero, and the second one
		// starts at the last microsecond so its departure wraps to 523.
		rows.push_back(want_row(KIND_DEQUEUE, 16'd0, 8'd0, 31'd0, 32'd0,
			VERDICT_DEQUEUED, 16'd0, 25'd0, 32'd0));
		rows.push_back(want_row(KIND_DEQUEUE, 16'hFFFF, 8'hFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
			VERDICT_DEQUEUED, 16'd0, 25'd0, 32'd523));
		// Flows outside the ramp are admitted, largest and smallest packets.
		rows.push_back(want_row(KIND_ENQUEUE, 16'hFFFF, 8'd0, 31'd0, 32'd0,
			VERDICT_ACCEPT, 16'd1, 25'd65535, 32'd0));
		rows.push_back(want_row(KIND_ENQUEUE, 16'd0, 8'hFF, 31'h7FFF_FFFF, 32'd0,
			VERDICT_ACCEPT, 16'd2, 25'd65535, 32'd0));
		// Ramp flow below and at the ramp minimum, then just inside it: a
		// zero draw drops, a draw of span minus one does not.
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd100, 8'd1, 31'd0, 32'd10));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd12345, 32'd20));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd7, 32'd30));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd3, 32'd40));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd0, 32'd50));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd119, 32'd60));
		// Departures with now ahead of, then behind, the last departure.
		rows.push_back(ev_row(KIND_DEQUEUE, 16'd1500, 8'd0, 31'd0, 32'd1000));
		rows.push_back(ev_row(KIND_DEQUEUE, 16'd1500, 8'd0, 31'd0, 32'd0));
		// Ramp minimum equal to maximum drops everything on the ramp flow.
		rows.push_back(reg_row(REG_RAMP_MAX, 32'd5));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'h7FFF_FFFF, 32'd70));
		// Maximum below minimum turns the ramp off.
		rows.push_back(reg_row(REG_RAMP_MAX, 32'd4));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd0, 32'd80));
		// Full-width ramp with a zero denominator: any count inside drops.
		rows.push_back(reg_row(REG_RAMP_MIN, 32'd0));
		rows.push_back(reg_row(REG_RAMP_MAX, 32'd65535));
		rows.push_back(reg_row(REG_RAMP_DENOM, 32'd0));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd0, 32'd90));
		// Largest denominator, ramp moved to flow 255.
		rows.push_back(reg_row(REG_RAMP_DENOM, 32'd255));
		rows.push_back(reg_row(REG_RAMP_FLOW, 32'd255));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'hFF, 31'd3, 32'd100));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd1, 31'd0, 32'd110));
		// Count limit reached, then byte limit reached, then a wide byte limit.
		rows.push_back(reg_row(REG_COUNT_LIMIT, 32'd1));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd0, 31'd0, 32'd120));
		rows.push_back(reg_row(REG_COUNT_LIMIT, 32'd65535));
		rows.push_back(reg_row(REG_BYTE_LIMIT, 32'd1));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'd64, 8'd0, 31'd0, 32'd130));
		rows.push_back(reg_row(REG_BYTE_LIMIT, 32'd16777215));
		rows.push_back(ev_row(KIND_ENQUEUE, 16'hFFFF, 8'd0, 31'd0, 32'd140));
		// Zero line rate counts as one bit per microsecond; largest latency.
		rows.push_back(reg_row(REG_LINE_RATE, 32'd0));
		rows.push_back(reg_row(REG_EXTRA_LATENCY, 32'd1048575));
		rows.push_back(ev_row(KIND_DEQUEUE, 16'hFFFF, 8'd0, 31'd0, 32'd5000));
		// Fastest line rate near the top of the time range, then draining
		// the bytes past zero.
		rows.push_back(reg_row(REG_LINE_RATE, 32'd65535));
		rows.push_back(ev_row(KIND_DEQUEUE, 16'hFFFF, 8'd0, 31'd0, 32'hFFFF_FF00));
		rows.push_back(ev_row(KIND_DEQUEUE, 16'hFFFF, 8'd0, 31'd0, 32'h0000_0100));
		rows.push_back(ev_row(KIND_DEQUEUE, 16'hFFFF, 8'd0, 31'd0, 32'h0000_0200));

		foreach (rows[i]) begin
			if (rows[i].what == ROW_WRITE) begin
				drain();
				cfg_write(rows[i].reg_idx, rows[i].value);
			end else begin
				offer(rows[i].ev, rows[i].has_want, rows[i].want);
			end
		end

		// Random phases, each under a fresh register setting. The second one
		// opens with a long output stall while events keep being offered.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			pick_setting();
			if (phase == 1)
				hold_pending = 1'b1;
			for (int n = 0; n < PHASE_EVENTS; n++)
				offer(random_event(), 1'b0, '0);
		end

		// Flood of maximum-size enqueues with the ramp and the limits off,
		// enough to drive the byte occupancy to its ceiling. No idling here.
		drain();
		calm = 1'b1;
		cfg_write(REG_COUNT_LIMIT, 32'd0);
		cfg_write(REG_BYTE_LIMIT, 32'd0);
		cfg_write(REG_RAMP_MIN, 32'd1);
		cfg_write(REG_RAMP_MAX, 32'd0);
		cfg_write(REG_LINE_RATE, span_pick(1, 65535, 65535));
		for (int n = 0; n < FLOOD_EVENTS; n++) begin
			ev = random_event();
			ev.kind = KIND_ENQUEUE;
			ev.size = '1;
			offer(ev, 1'b0, '0);
		end
		for (int n = 0; n < 4; n++) begin
			ev = random_event();
			ev.kind = KIND_DEQUEUE;
			offer(ev, 1'b0, '0);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0)
			$error("%0d expected results never arrived", pending_reports.size());

		$display("Ran %0d packet events under %0d register writes: every drop kind,", events_sent,
			settings_made);
		$display("departures across time wrap, a long output stall and byte saturation.");
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
